@@ src/rtal_pkg.sv @@
// ----------------------------------------------------------------------------
// rtal_pkg: shared types for the route and ARP lookup engine
// Item formats, function codes and the tokens that walk the cell chains.
// ----------------------------------------------------------------------------
`default_nettype none

package rtal_pkg;

	// Width of the hit index carried along the route chain; covers 256 routes.
	localparam int unsigned RT_IDX_W = 8;

	typedef enum logic [1:0] {
		FUNC_LOOKUP   = 2'd0,
		FUNC_ROUTE_WR = 2'd1,
		FUNC_ARP_WR   = 2'd2
	} func_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [3:0]  entry_index;
		logic [31:0] address;
		logic [31:0] mask;
		logic [31:0] gateway_address;
		logic [47:0] mac_value;
		logic        entry_valid;
	} req_t;

	typedef struct packed {
		logic        route_found;
		logic [3:0]  route_index;
		logic [31:0] next_hop;
		logic        on_link;
		logic        mac_found;
		logic [47:0] next_hop_mac;
	} rsp_t;

	// Write command broadcast to every cell of a chain.
	typedef struct packed {
		logic        en;
		logic [3:0]  index;
		logic [31:0] address;
		logic [31:0] mask;
		logic [31:0] gateway;
		logic [47:0] mac;
		logic        valid;
	} wr_cmd_t;

	// Lookup token moving through the route cells.
	typedef struct packed {
		logic                vld;
		logic                found;
		logic [RT_IDX_W-1:0] idx;
		logic [31:0]         addr;
		logic [31:0]         gw;
	} rt_tok_t;

	// Lookup token moving through the ARP cells.
	typedef struct packed {
		logic        vld;
		logic        route_found;
		logic [3:0]  route_index;
		logic [31:0] next_hop;
		logic        on_link;
		logic        mac_found;
		logic [47:0] mac;
	} arp_tok_t;

endpackage

`default_nettype wire

@@ src/rtal_route_cell.sv @@
// ----------------------------------------------------------------------------
// rtal_route_cell: one route table slot
// Holds one route and tests the passing token against it, first match wins.
// ----------------------------------------------------------------------------
`default_nettype none

module rtal_route_cell #(
	parameter int unsigned INDEX = 0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              adv,
	input  wire rtal_pkg::wr_cmd_t wr,
	input  wire rtal_pkg::rt_tok_t tok_in,
	output rtal_pkg::rt_tok_t      tok_out
);

	logic [31:0]       network_q;
	logic [31:0]       mask_q;
	logic [31:0]       gateway_q;
	logic              valid_q;
	logic              sel;
	logic              hit;
	rtal_pkg::rt_tok_t tok_nxt;
	rtal_pkg::rt_tok_t tok_q;

	assign sel = wr.en && (32'(wr.index) == 32'(INDEX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (sel) begin
			valid_q <= wr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sel) begin
			network_q <= wr.address;
			mask_q    <= wr.mask;
			gateway_q <= wr.gateway;
		end
	end

	assign hit = !tok_in.found && valid_q && ((tok_in.addr & mask_q) == network_q);

	always_comb begin
		tok_nxt = tok_in;
		if (hit) begin
			tok_nxt.found = 1'b1;
			tok_nxt.idx   = rtal_pkg::RT_IDX_W'(INDEX);
			tok_nxt.gw    = gateway_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (adv) begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_out = tok_q;

endmodule

`default_nettype wire

@@ src/rtal_arp_cell.sv @@
// ----------------------------------------------------------------------------
// rtal_arp_cell: one ARP cache slot
// Holds one address to MAC binding and resolves the passing next hop.
// ----------------------------------------------------------------------------
`default_nettype none

module rtal_arp_cell #(
	parameter int unsigned INDEX = 0
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               adv,
	input  wire rtal_pkg::wr_cmd_t  wr,
	input  wire rtal_pkg::arp_tok_t tok_in,
	output rtal_pkg::arp_tok_t      tok_out
);

	logic [31:0]        address_q;
	logic [47:0]        mac_q;
	logic               valid_q;
	logic               sel;
	logic               hit;
	rtal_pkg::arp_tok_t tok_nxt;
	rtal_pkg::arp_tok_t tok_q;

	assign sel = wr.en && (32'(wr.index) == 32'(INDEX));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (sel) begin
			valid_q <= wr.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sel) begin
			address_q <= wr.address;
			mac_q     <= wr.mac;
		end
	end

	// A failed route lookup never searches the cache.
	assign hit = tok_in.route_found && !tok_in.mac_found && valid_q &&
		(tok_in.next_hop == address_q);

	always_comb begin
		tok_nxt = tok_in;
		if (hit) begin
			tok_nxt.mac_found = 1'b1;
			tok_nxt.mac       = mac_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else if (adv) begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_out = tok_q;

endmodule

`default_nettype wire

@@ src/route_and_arp_lookup.sv @@
// ----------------------------------------------------------------------------
// route_and_arp_lookup: IPv4 next-hop lookup with route table and ARP cache
// First-match route search followed by an ARP resolution of the next hop.
// ----------------------------------------------------------------------------
// Usage:
// Request items arrive on req with req_valid and are taken at an edge where
// req_stall is low. A route write or an ARP write item stores its slot in the
// same edge and gives no result; a write to a slot beyond the table depth and
// an item with the unused function code are dropped. A lookup item gives one
// result item on rsp, handed over at an edge with rsp_valid high and
// rsp_stall low.
// A lookup token walks a row of route cells, one cell per cycle while the
// chain advances, then one junction stage that picks the next hop, then a
// row of ARP cells, and lands in the output register. req_stall stays high
// while a lookup is in flight and drops in the cycle the result is loaded,
// so a new lookup is taken only after the last one has left the chain.
// Write items are taken one per cycle while no lookup is in flight.
// The output register lets a new item in while a result waits; if a second
// result reaches the end of the chain before the first is taken, the whole
// chain holds still until rsp_stall drops.
// Reset clears every valid bit of both tables, the default gateway code and
// all control state; the table payload stays as it was.
// default_gateway_code is written through cfg_we and cfg_wdata, which the
// user must drive only while idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`default_nettype none

module route_and_arp_lookup #(
	parameter int unsigned ROUTE_ENTRIES = 16,
	parameter int unsigned ARP_ENTRIES   = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           cfg_we,
	input  wire logic [31:0]    cfg_wdata,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire rtal_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output rtal_pkg::rsp_t      rsp
);

	logic               accept;
	logic               adv;
	logic               busy_q;
	logic [31:0]        dflt_gw_q;
	logic               lookup_go;
	rtal_pkg::wr_cmd_t  route_wr;
	rtal_pkg::wr_cmd_t  arp_wr;
	rtal_pkg::rt_tok_t  rt_chain  [ROUTE_ENTRIES+1];
	rtal_pkg::arp_tok_t arp_chain [ARP_ENTRIES+1];
	rtal_pkg::arp_tok_t jct_q;
	rtal_pkg::arp_tok_t jct_nxt;
	rtal_pkg::arp_tok_t last_tok;
	logic               rsp_vld_q;
	rtal_pkg::rsp_t     rsp_q;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dflt_gw_q <= '0;
		end else if (cfg_we) begin
			dflt_gw_q <= cfg_wdata;
		end
	end

	// Only one lookup is in flight; writes are taken whenever no lookup is.
	assign req_stall = busy_q;
	assign accept    = req_valid && !busy_q;

	// Decode the function code into the lookup start and the write strobes.
	always_comb begin
		route_wr = '{en: 1'b0, index: req.entry_index, address: req.address,
			mask: req.mask, gateway: req.gateway_address, mac: req.mac_value,
			valid: req.entry_valid};
		arp_wr    = route_wr;
		lookup_go = 1'b0;
		unique case (req.func)
			rtal_pkg::FUNC_LOOKUP:   lookup_go   = accept;
			rtal_pkg::FUNC_ROUTE_WR: route_wr.en = accept;
			rtal_pkg::FUNC_ARP_WR:   arp_wr.en   = accept;
			default:                 lookup_go   = 1'b0;
		endcase
	end

	// The chain advances unless a finished token meets a full, stalled
	// output register.
	assign last_tok = arp_chain[ARP_ENTRIES];
	assign adv      = !(last_tok.vld && rsp_vld_q && rsp_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (lookup_go) begin
			busy_q <= 1'b1;
		end else if (last_tok.vld && adv) begin
			busy_q <= 1'b0;
		end
	end

	// Token entering the first route cell.
	assign rt_chain[0] = '{vld: lookup_go, found: 1'b0, idx: '0,
		addr: req.address, gw: '0};

	for (genvar i = 0; i < ROUTE_ENTRIES; i++) begin : g_route
		rtal_route_cell #(
			.INDEX(i)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.wr     (route_wr),
			.tok_in (rt_chain[i]),
			.tok_out(rt_chain[i+1])
		);
	end

	// Junction: choose the next hop from the matching route. A miss leaves
	// every result field at zero.
	always_comb begin
		jct_nxt             = '0;
		jct_nxt.vld         = rt_chain[ROUTE_ENTRIES].vld;
		jct_nxt.route_found = rt_chain[ROUTE_ENTRIES].found;
		if (rt_chain[ROUTE_ENTRIES].found) begin
			jct_nxt.route_index = rt_chain[ROUTE_ENTRIES].idx[3:0];
			if (rt_chain[ROUTE_ENTRIES].gw == dflt_gw_q) begin
				jct_nxt.on_link  = 1'b1;
				jct_nxt.next_hop = rt_chain[ROUTE_ENTRIES].addr;
			end else begin
				jct_nxt.next_hop = rt_chain[ROUTE_ENTRIES].gw;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			jct_q <= '0;
		end else if (adv) begin
			jct_q <= jct_nxt;
		end
	end

	assign arp_chain[0] = jct_q;

	for (genvar j = 0; j < ARP_ENTRIES; j++) begin : g_arp
		rtal_arp_cell #(
			.INDEX(j)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.wr     (arp_wr),
			.tok_in (arp_chain[j]),
			.tok_out(arp_chain[j+1])
		);
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_vld_q <= 1'b0;
		end else if (last_tok.vld && adv) begin
			rsp_vld_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (last_tok.vld && adv) begin
			rsp_q <= '{route_found: last_tok.route_found,
				route_index: last_tok.route_index, next_hop: last_tok.next_hop,
				on_link: last_tok.on_link, mac_found: last_tok.mac_found,
				next_hop_mac: last_tok.mac};
		end
	end

	assign rsp_valid = rsp_vld_q;
	assign rsp       = rsp_q;

endmodule

`default_nettype wire

@@ tb/sv/tb_route_and_arp_lookup.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_route_and_arp_lookup: self-checking bench for the next-hop lookup engine
// Sends route writes, ARP writes and lookups through the request channel.
// It predicts every lookup result from its own copy of both tables and
// compares it field by field with the response channel, under random idling
// on both sides and with default gateway code changes between phases.
// ----------------------------------------------------------------------------

module tb_route_and_arp_lookup;

	localparam int SLOTS = 16;
	// A lookup result shows once the request has passed the route cells, the
	// junction stage, the ARP cells and the output register.
	localparam int SETTLE_CYCLES = 40;
	// Longest stretch without any accepted item before the run is declared hung.
	localparam int HANG_LIMIT = 1000;
	localparam int POOL_SIZE = 12;
	// The one function code that the package leaves unused.
	localparam logic [1:0] FUNC_UNUSED = 2'd3;

	logic           clk = 1'b0;
	logic           arst_n = 1'b0;
	logic           cfg_we = 1'b0;
	logic [31:0]    cfg_wdata = '0;
	logic           req_valid = 1'b0;
	logic           req_stall;
	rtal_pkg::req_t req = '0;
	logic           rsp_valid;
	logic           rsp_stall = 1'b0;
	rtal_pkg::rsp_t rsp;

	route_and_arp_lookup dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Request items waiting to be sent, and lookup results waiting to arrive.
	rtal_pkg::req_t req_backlog [$];
	rtal_pkg::rsp_t expected_hops [$];

	// Predictor copy of the engine: both tables and the on-link gateway code.
	logic [31:0]      rt_net [SLOTS];
	logic [31:0]      rt_mask [SLOTS];
	logic [31:0]      rt_gw [SLOTS];
	logic [SLOTS-1:0] rt_live = '0;
	logic [31:0]      arp_ip [SLOTS];
	logic [47:0]      arp_hw [SLOTS];
	logic [SLOTS-1:0] arp_live = '0;
	logic [31:0]      onlink_code = '0;

	// What the stimulus generator has queued so far, used to aim lookups at
	// prefixes that are really in the table.
	logic [31:0]      gen_net [SLOTS];
	logic [31:0]      gen_mask [SLOTS];
	logic [SLOTS-1:0] gen_live = '0;
	logic [31:0]      gen_code = '0;
	logic [31:0]      ip_pool [POOL_SIZE];

	// Idling odds in percent, set per phase by the stimulus process.
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	int send_gap = 0;
	int stall_left = 0;
	int quiet_cycles = 0;
	int mismatches = 0;

	// First-match route search, then first-match ARP search on the next hop.
	// A lookup that finds no route returns all zero fields.
	function automatic rtal_pkg::rsp_t resolve_next_hop(input logic [31:0] dest);
		rtal_pkg::rsp_t r;
		int hit;
		r = '0;
		hit = -1;
		// Scanning downward leaves the lowest matching index in hit.
		for (int i = SLOTS - 1; i >= 0; i--)
			if (rt_live[i] && (dest & rt_mask[i]) == rt_net[i])
				hit = i;
		if (hit >= 0) begin
			r.route_found = 1'b1;
			r.route_index = hit[3:0];
			if (rt_gw[hit] == onlink_code) begin
				r.next_hop = dest;
				r.on_link = 1'b1;
			end else begin
				r.next_hop = rt_gw[hit];
			end
			for (int i = SLOTS - 1; i >= 0; i--)
				if (arp_live[i] && arp_ip[i] == r.next_hop) begin
					r.mac_found = 1'b1;
					r.next_hop_mac = arp_hw[i];
				end
		end
		return r;
	endfunction

	// Applies one accepted request item to the predictor.
	task automatic absorb_request(input rtal_pkg::req_t item);
		case (item.func)
			rtal_pkg::FUNC_ROUTE_WR: begin
				rt_net[item.entry_index] = item.address;
				rt_mask[item.entry_index] = item.mask;
				rt_gw[item.entry_index] = item.gateway_address;
				rt_live[item.entry_index] = item.entry_valid;
			end
			rtal_pkg::FUNC_ARP_WR: begin
				arp_ip[item.entry_index] = item.address;
				arp_hw[item.entry_index] = item.mac_value;
				arp_live[item.entry_index] = item.entry_valid;
			end
			rtal_pkg::FUNC_LOOKUP: begin
				expected_hops.push_back(resolve_next_hop(item.address));
			end
			default: begin
				// The unused function code is dropped by the engine.
			end
		endcase
	endtask

	task automatic check_field(input string field, input logic [47:0] want,
			input logic [47:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", field, want, got);
			mismatches++;
		end
	endtask

	// Driver: presents the next queued item once the current one is taken, and
	// holds valid low through a random gap now and then.
	always @(posedge clk) begin
		if (arst_n && (!req_valid || !req_stall)) begin
			if (send_gap > 0) begin
				send_gap--;
				req_valid <= 1'b0;
			end else if (req_backlog.size() > 0) begin
				req <= req_backlog.pop_front();
				req_valid <= 1'b1;
				if ($urandom_range(99, 0) < send_idle_pct)
					send_gap = $urandom_range(12, 1);
			end else begin
				req_valid <= 1'b0;
			end
		end
	end

	// Receiver: stalls in bursts that are unrelated to rsp_valid, so the bursts
	// land on every point of a lookup's walk and of the output hand-off.
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left--;
			rsp_stall <= 1'b1;
		end else begin
			rsp_stall <= 1'b0;
			if ($urandom_range(99, 0) < recv_idle_pct)
				stall_left = $urandom_range(12, 1);
		end
	end

	// Monitor: follows configuration writes and accepted requests, checks every
	// accepted result against the oldest prediction, and watches for a hang.
	always @(posedge clk) begin
		rtal_pkg::rsp_t want;
		if (arst_n) begin
			if (cfg_we)
				onlink_code = cfg_wdata;
			if (req_valid && !req_stall)
				absorb_request(req);
			if (rsp_valid && !rsp_stall) begin
				if (expected_hops.size() == 0) begin
					$error("lookup result with no lookup outstanding: %h", rsp);
					mismatches++;
				end else begin
					want = expected_hops.pop_front();
					check_field("route_found", 48'(want.route_found),
						48'(rsp.route_found));
					check_field("route_index", 48'(want.route_index),
						48'(rsp.route_index));
					check_field("next_hop", 48'(want.next_hop), 48'(rsp.next_hop));
					check_field("on_link", 48'(want.on_link), 48'(rsp.on_link));
					check_field("mac_found", 48'(want.mac_found), 48'(rsp.mac_found));
					check_field("next_hop_mac", want.next_hop_mac, rsp.next_hop_mac);
				end
			end
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= HANG_LIMIT) begin
					$display("== FAIL ==");
					$finish;
				end
			end
		end
	end

	function automatic rtal_pkg::req_t make_req(input logic [1:0] func,
			input logic [3:0] slot, input logic [31:0] addr, input logic [31:0] mask,
			input logic [31:0] gw, input logic [47:0] mac, input logic valid);
		rtal_pkg::req_t item;
		item.func = func;
		item.entry_index = slot;
		item.address = addr;
		item.mask = mask;
		item.gateway_address = gw;
		item.mac_value = mac;
		item.entry_valid = valid;
		return item;
	endfunction

	// Queues one item and keeps the generator's view of the route table.
	task automatic queue_item(input rtal_pkg::req_t item);
		if (item.func == rtal_pkg::FUNC_ROUTE_WR) begin
			gen_net[item.entry_index] = item.address;
			gen_mask[item.entry_index] = item.mask;
			gen_live[item.entry_index] = item.entry_valid;
		end
		req_backlog.push_back(item);
	endtask

	// Most writes build prefixes around a small pool of hosts and gateways, and
	// most lookups aim at those hosts or inside queued prefixes, so that routes,
	// on-link and off-link hops and ARP hits all come up often. The rest is
	// unaligned networks, plain random addresses and near misses.
	task automatic queue_random_items(input int count);
		rtal_pkg::req_t item;
		int pick;
		int slot;
		int len;
		logic [31:0] m;
		for (int n = 0; n < count; n++) begin
			item.entry_index = 4'($urandom);
			item.address = $urandom;
			item.mask = $urandom;
			item.gateway_address = $urandom;
			item.mac_value = 48'({$urandom, $urandom});
			item.entry_valid = ($urandom_range(7, 0) != 0);
			pick = $urandom_range(99, 0);
			slot = $urandom_range(SLOTS - 1, 0);
			if (pick < 14) begin
				len = $urandom_range(32, 0);
				m = 32'hFFFF_FFFF << (32 - len);
				item.func = rtal_pkg::FUNC_ROUTE_WR;
				item.mask = m;
				pick = $urandom_range(99, 0);
				if (pick < 50)
					item.address = ip_pool[$urandom_range(POOL_SIZE - 1, 0)] & m;
				else if (pick < 90)
					item.address = item.address & m;
				// Otherwise any bit set outside the mask keeps the route from matching.
				if ($urandom_range(2, 0) == 0)
					item.gateway_address = gen_code;
				else if ($urandom_range(4, 0) != 0)
					item.gateway_address = ip_pool[$urandom_range(3, 0)];
			end else if (pick < 28) begin
				item.func = rtal_pkg::FUNC_ARP_WR;
				if ($urandom_range(3, 0) != 0)
					item.address = ip_pool[$urandom_range(POOL_SIZE - 1, 0)];
			end else if (pick < 32) begin
				item.func = FUNC_UNUSED;
			end else begin
				item.func = rtal_pkg::FUNC_LOOKUP;
				pick = $urandom_range(99, 0);
				if (pick < 35) begin
					item.address = ip_pool[$urandom_range(POOL_SIZE - 1, 0)];
				end else if (pick < 75) begin
					if (gen_live[slot])
						item.address = (gen_net[slot] & gen_mask[slot]) |
							(item.address & ~gen_mask[slot]);
				end else if (pick >= 90) begin
					item.address = ip_pool[$urandom_range(POOL_SIZE - 1, 0)] ^
						(32'd1 << $urandom_range(31, 0));
				end
			end
			queue_item(item);
		end
	endtask

	// Waits until every queued item is taken and every lookup has answered,
	// then lets the chains run empty before the caller touches the register.
	task automatic wait_for_idle();
		@(negedge clk);
		while (req_backlog.size() != 0 || req_valid || expected_hops.size() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_gateway_code(input logic [31:0] code);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= code;
		gen_code = code;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(negedge clk);
	endtask

	task automatic run_phase(input logic [31:0] code, input int count,
			input int send_pct, input int recv_pct);
		write_gateway_code(code);
		send_idle_pct = send_pct;
		recv_idle_pct = recv_pct;
		queue_random_items(count);
		wait_for_idle();
	endtask

	initial begin
		for (int i = 0; i < POOL_SIZE; i++)
			ip_pool[i] = $urandom;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed part, with the gateway code still at its reset value of zero.
		send_idle_pct = 20;
		recv_idle_pct = 20;
		// Empty tables: no route, all fields zero.
		queue_item(make_req(rtal_pkg::FUNC_LOOKUP, 4'd0, 32'h0000_0000, '0, '0, '0,
			1'b0));
		queue_item(make_req(rtal_pkg::FUNC_ROUTE_WR, 4'd0, 32'h0A00_0000,
			32'hFF00_0000, 32'h0000_0000, '0, 1'b1));
		// A default route through 10.0.0.1.
		queue_item(make_req(rtal_pkg::FUNC_ROUTE_WR, 4'd1, 32'h0000_0000,
			32'h0000_0000, 32'h0A00_0001, '0, 1'b1));
		queue_item(make_req(rtal_pkg::FUNC_ROUTE_WR, 4'd15, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 32'hFFFF_FFFE, 48'hFFFF_FFFF_FFFF, 1'b1));
		queue_item(make_req(rtal_pkg::FUNC_ARP_WR, 4'd0, 32'h0A00_0001, '0, '0,
			48'hFFFF_FFFF_FFFF, 1'b1));
		queue_item(make_req(rtal_pkg::FUNC_ARP_WR, 4'd15, 32'h0A01_0203,
			32'hFFFF_FFFF, 32'hFFFF_FFFF, 48'h0000_0000_0000, 1'b1));
		// The unused function code with every field at all ones is dropped.
		queue_item(make_req(FUNC_UNUSED, 4'hF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			32'hFFFF_FFFF, 48'hFFFF_FFFF_FFFF, 1'b1));
		// On-link hit with an ARP entry whose MAC is zero, then an on-link miss.
		queue_item(make_req(rtal_pkg::FUNC_LOOKUP, 4'd0, 32'h0A01_0203, '0, '0, '0,
			1'b0));
		queue_item(make_req(rtal_pkg::FUNC_LOOKUP, 4'd0, 32'h0A09_0909, '0, '0, '0,
			1'b0));
		// Off-link through the default route; the host route at 15 loses to it.
		queue_item(make_req(rtal_pkg::FUNC_LOOKUP, 4'd0, 32'hC0A8_0101, '0, '0, '0,
			1'b0));
		queue_item(make_req(rtal_pkg::FUNC_LOOKUP, 4'd0, 32'hFFFF_FFFF, '0, '0, '0,
			1'b0));
		// An invalidating write still stores the fields but frees the slot.
		queue_item(make_req(rtal_pkg::FUNC_ROUTE_WR, 4'd1, 32'hC0A8_0101,
			32'hFFFF_FFFF, 32'h0A00_0001, '0, 1'b0));
		queue_item(make_req(rtal_pkg::FUNC_LOOKUP, 4'd0, 32'hFFFF_FFFF, '0, '0, '0,
			1'b0));
		queue_item(make_req(rtal_pkg::FUNC_LOOKUP, 4'd0, 32'hC0A8_0101, '0, '0, '0,
			1'b0));
		// Two ARP entries for one address: the lower slot wins until invalidated.
		queue_item(make_req(rtal_pkg::FUNC_ARP_WR, 4'd3, 32'h0A00_0001, '0, '0,
			48'h0123_4567_89AB, 1'b1));
		queue_item(make_req(rtal_pkg::FUNC_ROUTE_WR, 4'd2, 32'h0000_0000,
			32'h0000_0000, 32'h0A00_0001, '0, 1'b1));
		queue_item(make_req(rtal_pkg::FUNC_LOOKUP, 4'd0, 32'h0808_0808, '0, '0, '0,
			1'b0));
		queue_item(make_req(rtal_pkg::FUNC_ARP_WR, 4'd0, 32'h0A00_0001, '0, '0,
			48'hFFFF_FFFF_FFFF, 1'b0));
		queue_item(make_req(rtal_pkg::FUNC_LOOKUP, 4'd0, 32'h0808_0808, '0, '0, '0,
			1'b0));
		wait_for_idle();

		// With the code at all ones, a route whose gateway is all ones is on-link.
		write_gateway_code(32'hFFFF_FFFF);
		queue_item(make_req(rtal_pkg::FUNC_ROUTE_WR, 4'd0, 32'h0B00_0000,
			32'hFF00_0000, 32'hFFFF_FFFF, '0, 1'b1));
		queue_item(make_req(rtal_pkg::FUNC_LOOKUP, 4'd0, 32'h0B00_00FF, '0, '0, '0,
			1'b0));
		queue_item(make_req(rtal_pkg::FUNC_LOOKUP, 4'd0, 32'h0A01_0203, '0, '0, '0,
			1'b0));
		queue_item(make_req(rtal_pkg::FUNC_LOOKUP, 4'd0, 32'hFFFF_FFFF, '0, '0, '0,
			1'b0));
		wait_for_idle();

		// Random phases, each under its own gateway code and idling mix. The
		// pool code turns routes through that gateway into on-link routes.
		run_phase(32'hFFFF_FFFF, 200, 20, 20);
		run_phase($urandom, 200, 0, 30);
		run_phase(ip_pool[0], 150, 30, 0);
		run_phase(32'h0000_0000, 150, 15, 15);
		// The closing stretch runs with no idling on either side.
		run_phase(ip_pool[1], 130, 0, 0);

		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
